[rtl/cox_ph_gradient_engine_unit_macros.svh]
// ----------------------------------------------------------------------------
// Cox PH gradient engine assertion macros
// Shared concurrent assertion forms for the gradient engine.
// ----------------------------------------------------------------------------
`ifndef COX_PH_GRADIENT_ENGINE_UNIT_MACROS_SVH
`define COX_PH_GRADIENT_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define CPGE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CPGE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/coxph_pkg.sv]
// ----------------------------------------------------------------------------
// Cox PH gradient engine package
// Payload types, fixed-point constants and codes shared by the engine files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package coxph_pkg;

   localparam int unsigned MAX_SAMPLES_DEF  = 1024;
   localparam int unsigned TIME_BUCKETS_DEF = 256;

   localparam int unsigned EXP_W    = 32;
   localparam int unsigned RISK_W   = 42;
   localparam int unsigned EVCNT_W  = 11;
   localparam int unsigned FACTOR_W = 32;
   localparam int unsigned ACC_W    = 63;
   localparam int unsigned QUO_W    = 64;

   // ln2 in Q32, and 24*ln2 so that the range reduction starts non-negative
   localparam logic [37:0]        LN2_Q32   = 38'd2977044472;
   localparam logic signed [38:0] EXP_BIAS  = 39'sd71449067328;
   localparam logic signed [6:0]  K_START   = -7'sd24;
   localparam logic signed [6:0]  K_OFFSET  = 7'sd16;
   localparam logic [3:0]         EXP_TERMS = 4'd13;

   localparam logic [RISK_W-1:0]  RISK_MAX  = '1;
   localparam logic [EVCNT_W-1:0] COUNT_MAX = '1;
   localparam logic [ACC_W-1:0]   ACC_MAX   = 63'h4000_0000_0000_0000;

   localparam logic OP_LOAD      = 1'b0;
   localparam logic OP_READ      = 1'b1;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic signed [15:0] prediction;
      logic [7:0]         time_bucket;
      logic               is_event;
      logic               last_sample;
      logic [9:0]         read_index;
   } req_payload_type;

   typedef struct packed {
      logic [9:0]         sample_number;
      logic signed [31:0] gradient;
      logic signed [31:0] hessian;
      logic               status;
   } rsp_payload_type;

endpackage

`default_nettype wire

[rtl/coxph_if.sv]
// ----------------------------------------------------------------------------
// Cox PH gradient engine channels
// Valid/ready request and response interfaces carrying the packed payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface coxph_req_if import coxph_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface coxph_rsp_if import coxph_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cox_ph_gradient_engine_unit.sv]
// ----------------------------------------------------------------------------
// Cox PH gradient engine
// Breslow-form Cox gradient and hessian per sample, fixed point, with table
// build after the final sample load.
// ----------------------------------------------------------------------------
// One transaction at a time; req ready is high only while the sequencer is
// idle. A load that stores a sample first reduces the range (k the ln2
// exponent, at most 47 range steps), then sums 13 Taylor terms, each with a
// multiply, a divider start and a division in the shared 64-step restoring
// divider, and scales the sum. A dropped load (store full) stores nothing.
// A read goes through the sample RAM, the factor RAM and two passes through
// the multiplier (straight to the response when the index is out of range),
// and its response waits until the previous one is taken.
// A load marked last then builds the tables over L+1 buckets (L the highest
// bucket seen) and N stored samples: it clears each bucket, accumulates each
// sample, forms suffix risk sums from bucket L down, then the factors per
// bucket (two 64-step divisions for each non-empty risk sum).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "cox_ph_gradient_engine_unit_macros.svh"

module cox_ph_gradient_engine_unit import coxph_pkg::*; #(
   parameter int unsigned MAX_SAMPLES  = MAX_SAMPLES_DEF,
   parameter int unsigned TIME_BUCKETS = TIME_BUCKETS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   coxph_req_if.sink    req_chan,
   coxph_rsp_if.source  rsp_chan
);

   localparam int unsigned SW     = $clog2(MAX_SAMPLES);
   localparam int unsigned CW     = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned BW     = $clog2(TIME_BUCKETS);
   localparam int unsigned SAMP_W = EXP_W + BW + 1;
   localparam int unsigned TAB_W  = EVCNT_W + RISK_W;
   localparam int unsigned FAC_W  = 2 * FACTOR_W;

   localparam logic [4:0] ST_IDLE       = 5'd0;
   localparam logic [4:0] ST_EXP_RANGE  = 5'd1;
   localparam logic [4:0] ST_EXP_MUL    = 5'd2;
   localparam logic [4:0] ST_EXP_DSTART = 5'd3;
   localparam logic [4:0] ST_EXP_DIV    = 5'd4;
   localparam logic [4:0] ST_EXP_SCALE  = 5'd5;
   localparam logic [4:0] ST_CLR        = 5'd6;
   localparam logic [4:0] ST_ACC_RD     = 5'd7;
   localparam logic [4:0] ST_ACC_TAB    = 5'd8;
   localparam logic [4:0] ST_ACC_WR     = 5'd9;
   localparam logic [4:0] ST_SUF_RD     = 5'd10;
   localparam logic [4:0] ST_SUF_WR     = 5'd11;
   localparam logic [4:0] ST_FAC_RD     = 5'd12;
   localparam logic [4:0] ST_FAC_Q1     = 5'd13;
   localparam logic [4:0] ST_FAC_D1     = 5'd14;
   localparam logic [4:0] ST_FAC_D2     = 5'd15;
   localparam logic [4:0] ST_FAC_WR     = 5'd16;
   localparam logic [4:0] ST_RD_SAMPLE  = 5'd17;
   localparam logic [4:0] ST_RD_FAC     = 5'd18;
   localparam logic [4:0] ST_RD_MULG    = 5'd19;
   localparam logic [4:0] ST_RD_MULH    = 5'd20;
   localparam logic [4:0] ST_RD_OUT     = 5'd21;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
      if (v > 68'sd2147483647) begin
         return 32'sh7fff_ffff;
      end
      if (v < -68'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   function automatic logic [ACC_W-1:0] acc_add(input logic [ACC_W-1:0] a,
                                                input logic [QUO_W-1:0] b);
      logic [QUO_W:0] s;
      s = (QUO_W+1)'(a) + (QUO_W+1)'(b);
      if (s > (QUO_W+1)'(ACC_MAX)) begin
         return ACC_MAX;
      end
      return s[ACC_W-1:0];
   endfunction

   // control state
   logic [4:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [BW-1:0]         latest_ff, latest_in;
   logic                  closed_ff, closed_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [6:0]            div_cnt_ff;

   // datapath
   logic                  last_ff, last_in;
   logic                  event_ff, event_in;
   logic [BW-1:0]         bucket_ff, bucket_in;
   logic signed [6:0]     k_ff, k_in;
   logic [37:0]           r_ff, r_in;
   logic [32:0]           term_ff, term_in;
   logic [34:0]           sum_ff, sum_in;
   logic [3:0]            n_ff, n_in;
   logic signed [67:0]    prod_ff, prod_in;
   logic [SW-1:0]         ptr_ff, ptr_in;
   logic [BW-1:0]         t_ff, t_in;
   logic [RISK_W-1:0]     run_ff, run_in;
   logic [ACC_W-1:0]      a1_ff, a1_in, a2_ff, a2_in;
   logic [QUO_W-1:0]      q1_ff, q1_in;
   logic signed [31:0]    grad_ff, grad_in;
   logic                  oor_ff, oor_in;
   logic [9:0]            num_ff, num_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   // shared divider
   logic [RISK_W-1:0]     div_rem_ff, div_den_ff;
   logic [QUO_W-1:0]      div_quo_ff;
   logic                  div_start;
   logic [QUO_W-1:0]      div_dividend;
   logic [RISK_W-1:0]     div_divisor;
   logic [RISK_W:0]       div_trial;
   logic                  div_fit;
   logic                  div_done;

   // shared multiplier
   logic                  mul_en;
   logic signed [33:0]    mul_a, mul_b;

   // memories
   logic                  samp_we, samp_re;
   logic [SAMP_W-1:0]     samp_wdata, samp_q;
   logic                  tab_we, tab_re;
   logic [BW-1:0]         tab_waddr, tab_raddr;
   logic [TAB_W-1:0]      tab_wdata, tab_q;
   logic                  fac_we, fac_re;
   logic [FAC_W-1:0]      fac_wdata, fac_q;

   logic [EXP_W-1:0]      samp_exp;
   logic [BW-1:0]         samp_bkt;
   logic                  samp_evt;
   logic [RISK_W-1:0]     tab_risk;
   logic [EVCNT_W-1:0]    tab_cnt;
   logic signed [31:0]    fac_g, fac_h;

   // helpers
   logic signed [38:0]    x_s, r_start;
   logic [BW-1:0]         bucket_clamp;
   logic [CW-1:0]         base_count;
   logic [BW-1:0]         base_latest;
   logic                  rd_oor;
   logic                  rsp_free;
   logic signed [6:0]     s_val;
   logic [41:0]           shl_val;
   logic [EXP_W-1:0]      exp_val;
   logic [RISK_W:0]       risk_sum, run_sum;
   logic [RISK_W-1:0]     risk_new, run_new;
   logic [EVCNT_W-1:0]    cnt_new;
   logic signed [67:0]    g_full;
   logic signed [67:0]    a1_s, a2_s;

   assign samp_exp = samp_q[SAMP_W-1 -: EXP_W];
   assign samp_bkt = samp_q[BW:1];
   assign samp_evt = samp_q[0];
   assign tab_risk = tab_q[RISK_W-1:0];
   assign tab_cnt  = tab_q[TAB_W-1 -: EVCNT_W];
   assign fac_g    = fac_q[FAC_W-1 -: FACTOR_W];
   assign fac_h    = fac_q[FACTOR_W-1:0];

   assign x_s     = {{2{req_chan.data.prediction[15]}}, req_chan.data.prediction, 21'b0};
   assign r_start = x_s + EXP_BIAS;
   assign bucket_clamp = (32'(req_chan.data.time_bucket) >= TIME_BUCKETS) ?
                         BW'(TIME_BUCKETS - 1) : BW'(req_chan.data.time_bucket);
   assign base_count  = closed_ff ? '0 : count_ff;
   assign base_latest = closed_ff ? '0 : latest_ff;
   assign rd_oor = (32'(req_chan.data.read_index) >= 32'(count_ff)) ||
                   (32'(req_chan.data.read_index) >= MAX_SAMPLES);
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // 2^(k-16) scaling of the series sum
   always_comb begin
      s_val   = k_ff - K_OFFSET;
      shl_val = 42'(sum_ff) << s_val[2:0];
      if (!s_val[6]) begin
         exp_val = (s_val > 7'sd7 || shl_val[41:32] != '0) ? '1 : shl_val[31:0];
      end else begin
         exp_val = 32'(sum_ff >> 6'(-s_val));
      end
   end

   assign risk_sum = {1'b0, tab_risk} + (RISK_W+1)'(samp_exp);
   assign risk_new = risk_sum[RISK_W] ? RISK_MAX : risk_sum[RISK_W-1:0];
   assign cnt_new  = (samp_evt && tab_cnt != COUNT_MAX) ? tab_cnt + EVCNT_W'(1) : tab_cnt;
   assign run_sum  = {1'b0, run_ff} + {1'b0, tab_risk};
   assign run_new  = run_sum[RISK_W] ? RISK_MAX : run_sum[RISK_W-1:0];
   assign g_full   = (prod_ff >>> 16) - (samp_evt ? 68'sd65536 : 68'sd0);
   assign a1_s     = $signed({5'b0, a1_ff});
   assign a2_s     = $signed({5'b0, a2_ff});

   assign div_trial = {div_rem_ff, div_quo_ff[QUO_W-1]};
   assign div_fit   = div_trial >= {1'b0, div_den_ff};
   assign div_done  = (div_cnt_ff == '0);

   assign prod_in = 68'(mul_a) * 68'(mul_b);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      latest_in    = latest_ff;
      closed_in    = closed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      last_in      = last_ff;
      event_in     = event_ff;
      bucket_in    = bucket_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      term_in      = term_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      ptr_in       = ptr_ff;
      t_in         = t_ff;
      run_in       = run_ff;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      q1_in        = q1_ff;
      grad_in      = grad_ff;
      oor_in       = oor_ff;
      num_in       = num_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      mul_en       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      samp_we      = 1'b0;
      samp_re      = 1'b0;
      samp_wdata   = {exp_val, bucket_ff, event_ff};
      tab_we       = 1'b0;
      tab_re       = 1'b0;
      tab_waddr    = t_ff;
      tab_raddr    = t_ff;
      tab_wdata    = '0;
      fac_we       = 1'b0;
      fac_re       = 1'b0;
      fac_wdata    = {sat32(a1_s), sat32(a1_s - a2_s)};

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.data.opcode == OP_LOAD) begin
                  closed_in = 1'b0;
                  count_in  = base_count;
                  latest_in = base_latest;
                  last_in   = req_chan.data.last_sample;
                  event_in  = req_chan.data.is_event;
                  bucket_in = bucket_clamp;
                  r_in      = r_start[37:0];
                  k_in      = K_START;
                  t_in      = '0;
                  if (32'(base_count) < MAX_SAMPLES) begin
                     state_in = ST_EXP_RANGE;
                  end else if (req_chan.data.last_sample) begin
                     state_in = ST_CLR;
                  end
               end else begin
                  num_in   = req_chan.data.read_index;
                  oor_in   = rd_oor;
                  ptr_in   = SW'(req_chan.data.read_index);
                  state_in = rd_oor ? ST_RD_OUT : ST_RD_SAMPLE;
               end
            end
         end
         ST_EXP_RANGE: begin
            if (r_ff >= LN2_Q32) begin
               r_in = r_ff - LN2_Q32;
               k_in = k_ff + 7'sd1;
            end else begin
               term_in  = 33'h1_0000_0000;
               sum_in   = 35'h1_0000_0000;
               n_in     = 4'd1;
               state_in = ST_EXP_MUL;
            end
         end
         ST_EXP_MUL: begin
            mul_en   = 1'b1;
            mul_a    = $signed({1'b0, term_ff});
            mul_b    = $signed({2'b0, r_ff[31:0]});
            state_in = ST_EXP_DSTART;
         end
         ST_EXP_DSTART: begin
            div_start    = 1'b1;
            div_dividend = {30'b0, prod_ff[65:32]};
            div_divisor  = RISK_W'(n_ff);
            state_in     = ST_EXP_DIV;
         end
         ST_EXP_DIV: begin
            if (div_done) begin
               term_in  = div_quo_ff[32:0];
               sum_in   = sum_ff + {2'b0, div_quo_ff[32:0]};
               n_in     = n_ff + 4'd1;
               state_in = (n_ff == EXP_TERMS) ? ST_EXP_SCALE : ST_EXP_MUL;
            end
         end
         ST_EXP_SCALE: begin
            samp_we   = 1'b1;
            count_in  = count_ff + CW'(1);
            latest_in = (bucket_ff > latest_ff) ? bucket_ff : latest_ff;
            t_in      = '0;
            state_in  = last_ff ? ST_CLR : ST_IDLE;
         end
         ST_CLR: begin
            tab_we = 1'b1;
            if (t_ff == latest_ff) begin
               ptr_in = '0;
               t_in   = latest_ff;
               run_in = '0;
               state_in = (count_ff == '0) ? ST_SUF_RD : ST_ACC_RD;
            end else begin
               t_in = t_ff + BW'(1);
            end
         end
         ST_ACC_RD: begin
            samp_re  = 1'b1;
            state_in = ST_ACC_TAB;
         end
         ST_ACC_TAB: begin
            tab_re    = 1'b1;
            tab_raddr = samp_bkt;
            state_in  = ST_ACC_WR;
         end
         ST_ACC_WR: begin
            tab_we    = 1'b1;
            tab_waddr = samp_bkt;
            tab_wdata = {cnt_new, risk_new};
            if (CW'(ptr_ff) + CW'(1) == count_ff) begin
               t_in     = latest_ff;
               run_in   = '0;
               state_in = ST_SUF_RD;
            end else begin
               ptr_in   = ptr_ff + SW'(1);
               state_in = ST_ACC_RD;
            end
         end
         ST_SUF_RD: begin
            tab_re   = 1'b1;
            state_in = ST_SUF_WR;
         end
         ST_SUF_WR: begin
            tab_we    = 1'b1;
            tab_wdata = {tab_cnt, run_new};
            run_in    = run_new;
            if (t_ff == '0) begin
               a1_in    = '0;
               a2_in    = '0;
               state_in = ST_FAC_RD;
            end else begin
               t_in     = t_ff - BW'(1);
               state_in = ST_SUF_RD;
            end
         end
         ST_FAC_RD: begin
            tab_re   = 1'b1;
            state_in = ST_FAC_Q1;
         end
         ST_FAC_Q1: begin
            if (tab_risk == '0) begin
               state_in = ST_FAC_WR;
            end else begin
               div_start    = 1'b1;
               div_dividend = {21'b0, tab_cnt, 32'b0};
               div_divisor  = tab_risk;
               state_in     = ST_FAC_D1;
            end
         end
         ST_FAC_D1: begin
            if (div_done) begin
               q1_in        = div_quo_ff;
               div_start    = 1'b1;
               div_dividend = {div_quo_ff[47:0], 16'b0};
               div_divisor  = tab_risk;
               state_in     = ST_FAC_D2;
            end
         end
         ST_FAC_D2: begin
            if (div_done) begin
               a1_in    = acc_add(a1_ff, q1_ff);
               a2_in    = acc_add(a2_ff, div_quo_ff);
               state_in = ST_FAC_WR;
            end
         end
         ST_FAC_WR: begin
            fac_we = 1'b1;
            if (t_ff == latest_ff) begin
               closed_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               t_in     = t_ff + BW'(1);
               state_in = ST_FAC_RD;
            end
         end
         ST_RD_SAMPLE: begin
            samp_re  = 1'b1;
            state_in = ST_RD_FAC;
         end
         ST_RD_FAC: begin
            fac_re   = 1'b1;
            state_in = ST_RD_MULG;
         end
         ST_RD_MULG: begin
            mul_en   = 1'b1;
            mul_a    = {{2{fac_g[31]}}, fac_g};
            mul_b    = $signed({2'b0, samp_exp});
            state_in = ST_RD_MULH;
         end
         ST_RD_MULH: begin
            grad_in  = sat32(g_full);
            mul_en   = 1'b1;
            mul_a    = {{2{fac_h[31]}}, fac_h};
            mul_b    = $signed({2'b0, samp_exp});
            state_in = ST_RD_OUT;
         end
         ST_RD_OUT: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.sample_number = num_ff;
               rsp_data_in.gradient      = oor_ff ? '0 : grad_ff;
               rsp_data_in.hessian       = oor_ff ? '0 : sat32(prod_ff >>> 16);
               rsp_data_in.status        = oor_ff ? STATUS_RANGE : STATUS_OK;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         latest_ff    <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         latest_ff    <= latest_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
         if (div_start) begin
            div_cnt_ff <= 7'(QUO_W);
         end else if (!div_done) begin
            div_cnt_ff <= div_cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      event_ff    <= event_in;
      bucket_ff   <= bucket_in;
      k_ff        <= k_in;
      r_ff        <= r_in;
      term_ff     <= term_in;
      sum_ff      <= sum_in;
      n_ff        <= n_in;
      ptr_ff      <= ptr_in;
      t_ff        <= t_in;
      run_ff      <= run_in;
      a1_ff       <= a1_in;
      a2_ff       <= a2_in;
      q1_ff       <= q1_in;
      grad_ff     <= grad_in;
      oor_ff      <= oor_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
      if (mul_en) begin
         prod_ff <= prod_in;
      end
      if (div_start) begin
         div_rem_ff <= '0;
         div_quo_ff <= div_dividend;
         div_den_ff <= div_divisor;
      end else if (!div_done) begin
         div_rem_ff <= div_fit ? RISK_W'(div_trial - {1'b0, div_den_ff})
                               : div_trial[RISK_W-1:0];
         div_quo_ff <= {div_quo_ff[QUO_W-2:0], div_fit};
      end
   end

   coxph_ram #(.WIDTH(SAMP_W), .DEPTH(MAX_SAMPLES)) u_samp_ram (
      .clock   (clock),
      .wr_en   (samp_we),
      .wr_addr (SW'(count_ff)),
      .wr_data (samp_wdata),
      .rd_en   (samp_re),
      .rd_addr (ptr_ff),
      .rd_data (samp_q)
   );

   coxph_ram #(.WIDTH(TAB_W), .DEPTH(TIME_BUCKETS)) u_tab_ram (
      .clock   (clock),
      .wr_en   (tab_we),
      .wr_addr (tab_waddr),
      .wr_data (tab_wdata),
      .rd_en   (tab_re),
      .rd_addr (tab_raddr),
      .rd_data (tab_q)
   );

   coxph_ram #(.WIDTH(FAC_W), .DEPTH(TIME_BUCKETS)) u_fac_ram (
      .clock   (clock),
      .wr_en   (fac_we),
      .wr_addr (t_ff),
      .wr_data (fac_wdata),
      .rd_en   (fac_re),
      .rd_addr (samp_bkt),
      .rd_data (fac_q)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   `CPGE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      32'(count_ff) <= MAX_SAMPLES, "sample count beyond capacity")
   `CPGE_ASSERT_IMP(a_div_start_idle, clock, reset, div_start,
      div_cnt_ff == '0, "divider restarted while busy")
   `CPGE_ASSERT_NXT(a_build_closes, clock, reset, state_ff == ST_FAC_WR && t_ff == latest_ff,
      closed_ff && state_ff == ST_IDLE, "table build did not close the batch")
   `CPGE_ASSERT_IMP(a_rsp_origin, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_RD_OUT, "response raised outside read completion")

endmodule

`default_nettype wire

[rtl/coxph_ram.sv]
// ----------------------------------------------------------------------------
// Cox PH generic RAM
// Single write port, single read port, registered read data with enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module coxph_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
